[rtl/core/rgbc_pkg.sv]
// rgbc_pkg: shared types and constants of the rgb 3x3/5x5 convolution block
// used by rgbc_line_store, rgbc_mac and rgb_2d_convolution_zero_pad
package rgbc_pkg;

    localparam int KERNEL_SIZE_DEF = 3;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAX_HEIGHT_DEF  = 1024;
    localparam int COEF_FRAC_DEF   = 8;

    localparam int PIX_W     = 8;
    localparam int COEF_W    = 12;
    localparam int DIM_W     = 11;
    localparam int KROW_W    = 60;
    localparam int CFG_IDX_W = 3;
    localparam int DIM_RESET = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROW_0 = 3'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int NUM_CH   = 3;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } out_beat_t;

endpackage

[rtl/core/rgbc_line_store.sv]
// rgbc_line_store: ring of kernel_size+1 pixel rows, banked by row slot and column mod k
// each bank has one write and one registered read port; depends on rgbc_pkg
module rgbc_line_store #(
    parameter int KERNEL_SIZE = rgbc_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = rgbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic                                   wr_en,
    input  logic [$clog2(KERNEL_SIZE+1)-1:0]       wr_rbank,
    input  logic [(KERNEL_SIZE>1 ? $clog2(KERNEL_SIZE) : 1)-1:0] wr_cbank,
    input  logic [($clog2((MAX_WIDTH+KERNEL_SIZE-1)/KERNEL_SIZE))-1:0] wr_addr,
    input  rgbc_pkg::pixel_t                       wr_data,
    input  logic [($clog2((MAX_WIDTH+KERNEL_SIZE-1)/KERNEL_SIZE))-1:0] rd_addr [KERNEL_SIZE],
    output rgbc_pkg::pixel_t                       rd_data [KERNEL_SIZE+1][KERNEL_SIZE]
);
    localparam int RING  = KERNEL_SIZE + 1;
    localparam int DEPTH = (MAX_WIDTH + KERNEL_SIZE - 1) / KERNEL_SIZE;
    localparam int RBW   = $clog2(RING);
    localparam int CBW   = KERNEL_SIZE > 1 ? $clog2(KERNEL_SIZE) : 1;

    for (genvar r = 0; r < RING; r++) begin : g_row
        for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_col
            rgbc_pkg::pixel_t mem [DEPTH];

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (wr_en && wr_rbank == RBW'(r) && wr_cbank == CBW'(c)) begin
                        mem[wr_addr] <= wr_data;
                    end
                    rd_data[r][c] <= mem[rd_addr[c]];
                end
            end
        end
    end

endmodule

[rtl/core/rgbc_mac.sv]
// rgbc_mac: tap selection, coefficient multiply, row sums, total and clamp to 0..255
// two register stages; depends on rgbc_pkg
module rgbc_mac #(
    parameter int KERNEL_SIZE    = rgbc_pkg::KERNEL_SIZE_DEF,
    parameter int COEF_FRAC_BITS = rgbc_pkg::COEF_FRAC_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic                               in_last,
    input  rgbc_pkg::pixel_t                   bank_data [KERNEL_SIZE+1][KERNEL_SIZE],
    input  logic [$clog2(KERNEL_SIZE+1)-1:0]   row_bank [KERNEL_SIZE],
    input  logic                               row_ok [KERNEL_SIZE],
    input  logic [(KERNEL_SIZE>1 ? $clog2(KERNEL_SIZE) : 1)-1:0] col_bank [KERNEL_SIZE],
    input  logic                               col_ok [KERNEL_SIZE],
    input  rgbc_pkg::coef_t                    coef [KERNEL_SIZE][KERNEL_SIZE],
    output logic                               out_valid,
    output rgbc_pkg::out_beat_t                out_beat
);
    localparam int PROD_W = rgbc_pkg::PIX_W + rgbc_pkg::COEF_W + 1;
    localparam int ROW_W  = PROD_W + $clog2(KERNEL_SIZE + 1);
    localparam int SUM_W  = ROW_W + $clog2(KERNEL_SIZE + 1);
    localparam int NCH    = rgbc_pkg::NUM_CH;

    logic signed [PROD_W-1:0] prod_next [NCH][KERNEL_SIZE][KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod_reg  [NCH][KERNEL_SIZE][KERNEL_SIZE];
    logic signed [ROW_W-1:0]  rsum_next [NCH][KERNEL_SIZE];
    logic signed [ROW_W-1:0]  rsum_reg  [NCH][KERNEL_SIZE];
    logic signed [SUM_W-1:0]  total     [NCH];
    logic                     v4_reg, v5_reg, last4_reg, last5_reg;

    function automatic logic [rgbc_pkg::PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] q;
        q = s >>> COEF_FRAC_BITS;
        if (s <= 0) begin
            return '0;
        end else if (q > SUM_W'(255)) begin
            return 8'hFF;
        end else begin
            return q[rgbc_pkg::PIX_W-1:0];
        end
    endfunction

    // tap select and multiply
    always_comb begin
        rgbc_pkg::pixel_t         p;
        logic [rgbc_pkg::PIX_W-1:0] chv [NCH];
        for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
            for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
                p = (row_ok[ky] && col_ok[kx]) ? bank_data[row_bank[ky]][col_bank[kx]] : '0;
                chv[rgbc_pkg::CH_RED]   = p.red;
                chv[rgbc_pkg::CH_GREEN] = p.green;
                chv[rgbc_pkg::CH_BLUE]  = p.blue;
                for (int ch = 0; ch < NCH; ch++) begin
                    prod_next[ch][ky][kx] = PROD_W'($signed({1'b0, chv[ch]}))
                                          * PROD_W'(coef[ky][kx]);
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
                rsum_next[ch][ky] = '0;
                for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
                    rsum_next[ch][ky] = rsum_next[ch][ky] + ROW_W'(prod_reg[ch][ky][kx]);
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            total[ch] = '0;
            for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
                total[ch] = total[ch] + SUM_W'(rsum_reg[ch][ky]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            rsum_reg  <= rsum_next;
            last4_reg <= in_last;
            last5_reg <= last4_reg;
        end
    end

    assign out_valid         = v5_reg;
    assign out_beat.px.red   = clamp_pix(total[rgbc_pkg::CH_RED]);
    assign out_beat.px.green = clamp_pix(total[rgbc_pkg::CH_GREEN]);
    assign out_beat.px.blue  = clamp_pix(total[rgbc_pkg::CH_BLUE]);
    assign out_beat.last     = last5_reg;

endmodule

[rtl/core/rgb_2d_convolution_zero_pad.sv]
// rgb_2d_convolution_zero_pad: streaming rgb k x k convolution with zero padding
// a result goes through stages 1 to 3, the rgbc_mac registers and the result queue to m_valid
// throughput: one input beat per cycle while s_ready is high, at most one result per input beat
// rate is set by one write and one registered read per line store bank each cycle
// reset: counters cleared, sizes to min(1024, MAX_*), kernel zero; line store not cleared
// depends on rgbc_pkg, rgbc_line_store, rgbc_mac
module rgb_2d_convolution_zero_pad #(
    parameter int KERNEL_SIZE    = rgbc_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH      = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT     = rgbc_pkg::MAX_HEIGHT_DEF,
    parameter int COEF_FRAC_BITS = rgbc_pkg::COEF_FRAC_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgbc_pkg::KROW_W-1:0]         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [rgbc_pkg::PIX_W-1:0]          s_red_in,
    input  logic [rgbc_pkg::PIX_W-1:0]          s_green_in,
    input  logic [rgbc_pkg::PIX_W-1:0]          s_blue_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rgbc_pkg::PIX_W-1:0]          m_red_out,
    output logic [rgbc_pkg::PIX_W-1:0]          m_green_out,
    output logic [rgbc_pkg::PIX_W-1:0]          m_blue_out,
    output logic                                m_frame_last
);
    localparam int RING  = KERNEL_SIZE + 1;
    localparam int HALF  = KERNEL_SIZE / 2;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int DEPTH = (MAX_WIDTH + KERNEL_SIZE - 1) / KERNEL_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int RBW   = $clog2(RING);
    localparam int CBW   = KERNEL_SIZE > 1 ? $clog2(KERNEL_SIZE) : 1;
    localparam int CWID  = rgbc_pkg::COEF_W;
    localparam int W_RST = MAX_WIDTH < rgbc_pkg::DIM_RESET ? MAX_WIDTH : rgbc_pkg::DIM_RESET;
    localparam int H_RST = MAX_HEIGHT < rgbc_pkg::DIM_RESET ? MAX_HEIGHT : rgbc_pkg::DIM_RESET;

    // configuration
    logic [WW-1:0]   w_reg;
    logic [RW-1:0]   h_reg;
    rgbc_pkg::coef_t coef_reg [KERNEL_SIZE][KERNEL_SIZE];

    // stage 1: input register
    logic             v1_reg, op1_reg;
    rgbc_pkg::pixel_t px1_reg;

    // position counters with running column div/mod k and row mod ring
    logic [CW-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [AW-1:0]  in_cq_reg, in_cq_next, out_cq_reg, out_cq_next;
    logic [CBW-1:0] in_cr_reg, in_cr_next, out_cr_reg, out_cr_next;
    logic [RBW-1:0] in_rm_reg, in_rm_next, out_rm_reg, out_rm_next;

    // stage 2 and 3: read address and tap selection
    logic           v2_reg, v3_reg, last2_reg, last3_reg;
    logic [AW-1:0]  rd_addr_next [KERNEL_SIZE];
    logic [AW-1:0]  rd_addr_reg  [KERNEL_SIZE];
    logic [RBW-1:0] rbank_next [KERNEL_SIZE], rbank2_reg [KERNEL_SIZE], rbank3_reg [KERNEL_SIZE];
    logic [CBW-1:0] cbank_next [KERNEL_SIZE], cbank2_reg [KERNEL_SIZE], cbank3_reg [KERNEL_SIZE];
    logic           rok_next [KERNEL_SIZE], rok2_reg [KERNEL_SIZE], rok3_reg [KERNEL_SIZE];
    logic           cok_next [KERNEL_SIZE], cok2_reg [KERNEL_SIZE], cok3_reg [KERNEL_SIZE];

    logic wr, emit, last_pos, adv, push, pop, cfg_we;
    int   in_row_w, in_col_w, need_r, need_c;

    rgbc_pkg::pixel_t    bank_data [RING][KERNEL_SIZE];
    logic                mac_valid;
    rgbc_pkg::out_beat_t mac_beat;

    // result queue, two entries
    logic [1:0]          cnt_reg;
    rgbc_pkg::out_beat_t head_reg, tail_reg;

    function automatic int clamp_dim(input logic [rgbc_pkg::DIM_W-1:0] v, input int mx);
        int d;
        d = int'(v);
        if (d < 1) begin
            d = 1;
        end else if (d > mx) begin
            d = mx;
        end
        return d;
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign adv       = cnt_reg != 2'd2;
    assign s_ready   = adv;
    assign pop       = (cnt_reg != 2'd0) && m_ready;
    assign push      = adv && mac_valid;

    // position bookkeeping and emit decision
    always_comb begin
        wr = v1_reg && (op1_reg == rgbc_pkg::OP_PIXEL) && (in_row_reg < h_reg);

        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        in_cq_next  = in_cq_reg;
        in_cr_next  = in_cr_reg;
        in_rm_next  = in_rm_reg;
        if (wr) begin
            if (int'(in_col_reg) + 1 >= int'(w_reg)) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
                in_cq_next  = '0;
                in_cr_next  = '0;
                in_rm_next  = (int'(in_rm_reg) + 1 >= RING) ? '0 : in_rm_reg + RBW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
                if (int'(in_cr_reg) + 1 >= KERNEL_SIZE) begin
                    in_cr_next = '0;
                    in_cq_next = in_cq_reg + AW'(1);
                end else begin
                    in_cr_next = in_cr_reg + CBW'(1);
                end
            end
        end

        in_row_w = int'(in_row_next);
        in_col_w = int'(in_col_next);
        need_r   = int'(out_row_reg) + HALF;
        if (need_r > int'(h_reg) - 1) begin
            need_r = int'(h_reg) - 1;
        end
        need_c = int'(out_col_reg) + HALF;
        if (need_c > int'(w_reg) - 1) begin
            need_c = int'(w_reg) - 1;
        end
        emit = v1_reg && !((in_row_w < int'(h_reg)) &&
               (in_row_w < need_r || (in_row_w == need_r && in_col_w <= need_c)));
        last_pos = (int'(out_row_reg) == int'(h_reg) - 1) &&
                   (int'(out_col_reg) == int'(w_reg) - 1);

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_cq_next  = out_cq_reg;
        out_cr_next  = out_cr_reg;
        out_rm_next  = out_rm_reg;
        if (emit) begin
            if (last_pos) begin
                in_col_next  = '0;
                in_row_next  = '0;
                in_cq_next   = '0;
                in_cr_next   = '0;
                in_rm_next   = '0;
                out_col_next = '0;
                out_row_next = '0;
                out_cq_next  = '0;
                out_cr_next  = '0;
                out_rm_next  = '0;
            end else if (int'(out_col_reg) + 1 >= int'(w_reg)) begin
                out_col_next = '0;
                out_row_next = out_row_reg + RW'(1);
                out_cq_next  = '0;
                out_cr_next  = '0;
                out_rm_next  = (int'(out_rm_reg) + 1 >= RING) ? '0 : out_rm_reg + RBW'(1);
            end else begin
                out_col_next = out_col_reg + CW'(1);
                if (int'(out_cr_reg) + 1 >= KERNEL_SIZE) begin
                    out_cr_next = '0;
                    out_cq_next = out_cq_reg + AW'(1);
                end else begin
                    out_cr_next = out_cr_reg + CBW'(1);
                end
            end
        end
    end

    // neighborhood addressing for the current output position
    always_comb begin
        int s, a, p;
        for (int b = 0; b < KERNEL_SIZE; b++) begin
            rd_addr_next[b] = '0;
        end
        for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
            s = int'(out_cr_reg) + kx - HALF;
            a = int'(out_cq_reg);
            if (s < 0) begin
                s = s + KERNEL_SIZE;
                a = a - 1;
            end else if (s >= KERNEL_SIZE) begin
                s = s - KERNEL_SIZE;
                a = a + 1;
            end
            rd_addr_next[CBW'(s)] = AW'(a);
            cbank_next[kx] = CBW'(s);
            p = int'(out_col_reg) + kx - HALF;
            cok_next[kx] = (p >= 0) && (p < int'(w_reg));
        end
        for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
            s = int'(out_rm_reg) + ky - HALF;
            if (s < 0) begin
                s = s + RING;
            end else if (s >= RING) begin
                s = s - RING;
            end
            rbank_next[ky] = RBW'(s);
            p = int'(out_row_reg) + ky - HALF;
            rok_next[ky] = (p >= 0) && (p < int'(h_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= WW'(W_RST);
            h_reg       <= RW'(H_RST);
            for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
                for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
                    coef_reg[ky][kx] <= '0;
                end
            end
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_cq_reg   <= '0;
            in_cr_reg   <= '0;
            in_rm_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_cq_reg  <= '0;
            out_cr_reg  <= '0;
            out_rm_reg  <= '0;
        end else if (cfg_we) begin
            if (cfg_index == rgbc_pkg::REG_IMAGE_WIDTH) begin
                w_reg <= WW'(clamp_dim(cfg_data[rgbc_pkg::DIM_W-1:0], MAX_WIDTH));
            end
            if (cfg_index == rgbc_pkg::REG_IMAGE_HEIGHT) begin
                h_reg <= RW'(clamp_dim(cfg_data[rgbc_pkg::DIM_W-1:0], MAX_HEIGHT));
            end
            for (int ky = 0; ky < KERNEL_SIZE; ky++) begin
                if (cfg_index == rgbc_pkg::REG_KERNEL_ROW_0 + rgbc_pkg::CFG_IDX_W'(ky)) begin
                    for (int kx = 0; kx < KERNEL_SIZE; kx++) begin
                        coef_reg[ky][kx] <= cfg_data[CWID*kx +: CWID];
                    end
                end
            end
            if (cfg_index == rgbc_pkg::REG_IMAGE_WIDTH ||
                cfg_index == rgbc_pkg::REG_IMAGE_HEIGHT) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                in_cq_reg   <= '0;
                in_cr_reg   <= '0;
                in_rm_reg   <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
                out_cq_reg  <= '0;
                out_cr_reg  <= '0;
                out_rm_reg  <= '0;
            end
        end else if (adv) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_cq_reg   <= in_cq_next;
            in_cr_reg   <= in_cr_next;
            in_rm_reg   <= in_rm_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_cq_reg  <= out_cq_next;
            out_cr_reg  <= out_cr_next;
            out_rm_reg  <= out_rm_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= emit;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg       <= s_operation;
            px1_reg.red   <= s_red_in;
            px1_reg.green <= s_green_in;
            px1_reg.blue  <= s_blue_in;
            last2_reg     <= last_pos;
            last3_reg     <= last2_reg;
            rd_addr_reg   <= rd_addr_next;
            rbank2_reg    <= rbank_next;
            cbank2_reg    <= cbank_next;
            rok2_reg      <= rok_next;
            cok2_reg      <= cok_next;
            rbank3_reg    <= rbank2_reg;
            cbank3_reg    <= cbank2_reg;
            rok3_reg      <= rok2_reg;
            cok3_reg      <= cok2_reg;
        end
    end

    rgbc_line_store #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_line_store (
        .aclk     (aclk),
        .en       (adv),
        .wr_en    (wr),
        .wr_rbank (in_rm_reg),
        .wr_cbank (in_cr_reg),
        .wr_addr  (in_cq_reg),
        .wr_data  (px1_reg),
        .rd_addr  (rd_addr_reg),
        .rd_data  (bank_data)
    );

    rgbc_mac #(
        .KERNEL_SIZE    (KERNEL_SIZE),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_last   (last3_reg),
        .bank_data (bank_data),
        .row_bank  (rbank3_reg),
        .row_ok    (rok3_reg),
        .col_bank  (cbank3_reg),
        .col_ok    (cok3_reg),
        .coef      (coef_reg),
        .out_valid (mac_valid),
        .out_beat  (mac_beat)
    );

    // output queue lets the pipeline keep moving while a beat waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case (cnt_reg)
                2'd0: begin
                    if (push) begin
                        head_reg <= mac_beat;
                        cnt_reg  <= 2'd1;
                    end
                end
                2'd1: begin
                    if (push && pop) begin
                        head_reg <= mac_beat;
                    end else if (push) begin
                        tail_reg <= mac_beat;
                        cnt_reg  <= 2'd2;
                    end else if (pop) begin
                        cnt_reg <= 2'd0;
                    end
                end
                2'd2: begin
                    if (pop) begin
                        head_reg <= tail_reg;
                        cnt_reg  <= 2'd1;
                    end
                end
                default: begin
                    cnt_reg <= 2'd0;
                end
            endcase
        end
    end

    assign m_valid      = cnt_reg != 2'd0;
    assign m_red_out    = head_reg.px.red;
    assign m_green_out  = head_reg.px.green;
    assign m_blue_out   = head_reg.px.blue;
    assign m_frame_last = head_reg.last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("result queue overflow");

    a_out_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_row_reg < h_reg) && (WW'(out_col_reg) < w_reg))
        else $error("output position outside frame");

    a_in_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_row_reg <= h_reg) && (WW'(in_col_reg) < w_reg))
        else $error("input position outside frame");

    a_bank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(in_cr_reg) < KERNEL_SIZE) && (int'(out_cr_reg) < KERNEL_SIZE) &&
        (int'(in_rm_reg) < RING) && (int'(out_rm_reg) < RING))
        else $error("line store bank index out of range");

endmodule
